@@ hdl/gwm_pkg.sv @@
// ----------------------------------------------------------------------------
// gwm_pkg: shared types and constants of the glob wildcard matcher
// Pattern size, token kinds, tokenizer states, register indexes and the
// token write word that the tokenizer broadcasts to the position cells.
// ----------------------------------------------------------------------------
package gwm_pkg;

	localparam int PAT_MAX = 32;            // pattern bytes held
	localparam int POS_W   = PAT_MAX + 1;   // positions, end position included
	localparam int IDX_W   = $clog2(POS_W); // holds a position 0..PAT_MAX
	localparam int CELL_W  = $clog2(PAT_MAX);

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [2:0] CFG_WORD0  = 3'd0;
	localparam logic [2:0] CFG_WORD1  = 3'd1;
	localparam logic [2:0] CFG_WORD2  = 3'd2;
	localparam logic [2:0] CFG_WORD3  = 3'd3;
	localparam logic [2:0] CFG_LENGTH = 3'd4;

	// TK_PASS marks the inside of a double star (second star and the slashes
	// it swallows): never active on its own, it only carries the closure on.
	typedef enum logic [2:0] {
		TK_NONE,
		TK_LIT,
		TK_ANY1,
		TK_RUN,
		TK_DEEP,
		TK_PASS
	} tok_kind_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_SCAN,
		T_LOAD
	} tok_state_t;

	typedef enum logic [1:0] {
		M_TOKEN,
		M_STAR2,
		M_SLASH
	} scan_mode_t;

	typedef struct packed {
		logic              clear;
		logic              we;
		logic [CELL_W-1:0] idx;
		tok_kind_t         kind;
		logic              slash_ok;
		logic [7:0]        lit;
	} tok_wr_t;

endpackage

@@ hdl/gwm_cell.sv @@
// ----------------------------------------------------------------------------
// gwm_cell: one pattern position of the matcher
// Holds the token of its position and whether the position is reachable.
// Per text byte it keeps itself (star runs) or hands a step to its right
// neighbor (literal and single wildcard).
// ----------------------------------------------------------------------------
module gwm_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  gwm_pkg::tok_wr_t tok,
	input  logic             sel,
	input  logic [7:0]       text_byte,
	input  logic             step_in,
	input  logic             act_load,
	input  logic             act_d,
	output logic             act,
	output logic             nxt,
	output logic             step_out,
	output logic             prop
);
	import gwm_pkg::*;

	tok_kind_t  kind_q;
	logic       slash_ok_q;
	logic [7:0] lit_q;
	logic       act_q;
	logic       ok;
	logic       keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= TK_NONE;
		end else if (tok.clear) begin
			kind_q <= TK_NONE;
		end else if (tok.we && sel) begin
			kind_q <= tok.kind;
		end
	end

	always_ff @(posedge clk) begin
		if (tok.we && sel) begin
			slash_ok_q <= tok.slash_ok;
			lit_q      <= tok.lit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (act_load) begin
			act_q <= act_d;
		end
	end

	always_comb begin
		ok       = (text_byte != CH_SLASH) || slash_ok_q;
		keep     = 1'b0;
		step_out = 1'b0;
		prop     = 1'b0;
		unique case (kind_q)
			TK_RUN: begin
				keep = act_q && ok;
				prop = 1'b1;
			end
			TK_DEEP: begin
				keep = act_q;
				prop = 1'b1;
			end
			TK_PASS: begin
				prop = 1'b1;
			end
			TK_ANY1: begin
				step_out = act_q && ok;
			end
			TK_LIT: begin
				step_out = act_q && (lit_q == text_byte);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign nxt = keep || step_in;
	assign act = act_q;

endmodule

@@ hdl/gwm_tokenizer.sv @@
// ----------------------------------------------------------------------------
// gwm_tokenizer: pattern registers and token sweep
// Holds the pattern words and length. After reset and after each register
// write it walks the pattern one position a cycle, writes each cell's token
// and finds the end position, then asks for the start set to be loaded.
// ----------------------------------------------------------------------------
module gwm_tokenizer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [2:0]              cfg_index,
	input  logic [63:0]             cfg_data,
	output gwm_pkg::tok_wr_t        tok,
	output logic                    busy,
	output logic                    load_start,
	output logic [gwm_pkg::IDX_W-1:0] len
);
	import gwm_pkg::*;

	logic [63:0]      pattern_word_q [4];
	logic [5:0]       pattern_length_q;
	tok_state_t       state_q, state_d;
	scan_mode_t       mode_q, mode_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] len_q, len_d;
	logic             deep_q, deep_d;
	logic             restart;
	logic [IDX_W-1:0] n_eff;
	logic [IDX_W-1:0] idx_p1;
	logic [7:0]       byte_cur;
	logic [7:0]       byte_nxt;
	logic             end_hit;

	function automatic logic [7:0] pat_byte(input logic [63:0] w [4],
		input logic [CELL_W-1:0] i);
		return w[i[4:3]][{i[2:0], 3'b000} +: 8];
	endfunction

	assign restart = cfg_wr_en && (cfg_index <= CFG_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_word_q[0] <= '0;
			pattern_word_q[1] <= '0;
			pattern_word_q[2] <= '0;
			pattern_word_q[3] <= '0;
			pattern_length_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WORD0:  pattern_word_q[0] <= cfg_data;
				CFG_WORD1:  pattern_word_q[1] <= cfg_data;
				CFG_WORD2:  pattern_word_q[2] <= cfg_data;
				CFG_WORD3:  pattern_word_q[3] <= cfg_data;
				CFG_LENGTH: pattern_length_q  <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	assign n_eff    = (pattern_length_q > 6'(PAT_MAX)) ? IDX_W'(PAT_MAX)
		: IDX_W'(pattern_length_q);
	assign idx_p1   = idx_q + IDX_W'(1);
	assign byte_cur = pat_byte(pattern_word_q, idx_q[CELL_W-1:0]);
	assign byte_nxt = pat_byte(pattern_word_q, idx_p1[CELL_W-1:0]);
	assign end_hit  = (idx_q >= n_eff) || (byte_cur == CH_NUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_SCAN;
			mode_q  <= M_TOKEN;
			idx_q   <= '0;
			len_q   <= '0;
			deep_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
			deep_q  <= deep_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		idx_d        = idx_q;
		len_d        = len_q;
		deep_d       = deep_q;
		tok.clear    = restart;
		tok.we       = 1'b0;
		tok.idx      = idx_q[CELL_W-1:0];
		tok.kind     = TK_NONE;
		tok.slash_ok = deep_q;
		tok.lit      = byte_cur;
		load_start   = 1'b0;
		unique case (state_q)
			T_IDLE: begin
			end
			T_SCAN: begin
				if (end_hit) begin
					len_d   = idx_q;
					state_d = T_LOAD;
				end else begin
					tok.we = 1'b1;
					idx_d  = idx_p1;
					if (mode_q == M_STAR2) begin
						tok.kind = TK_PASS;
						mode_d   = M_SLASH;
					end else if (mode_q == M_SLASH && byte_cur == CH_SLASH) begin
						tok.kind = TK_PASS;
					end else if (byte_cur == CH_STAR && idx_p1 < n_eff
						&& byte_nxt == CH_STAR) begin
						tok.kind = TK_DEEP;
						deep_d   = 1'b1;
						mode_d   = M_STAR2;
					end else begin
						mode_d = M_TOKEN;
						if (byte_cur == CH_STAR) begin
							tok.kind = TK_RUN;
						end else if (byte_cur == CH_QUEST) begin
							tok.kind = TK_ANY1;
						end else begin
							tok.kind = TK_LIT;
						end
					end
				end
			end
			T_LOAD: begin
				load_start = 1'b1;
				state_d    = T_IDLE;
			end
			default: begin
				state_d = T_IDLE;
			end
		endcase
		// A register write starts the sweep over, whatever was in progress.
		if (restart) begin
			state_d = T_SCAN;
			mode_d  = M_TOKEN;
			idx_d   = '0;
			deep_d  = 1'b0;
		end
	end

	assign busy = (state_q != T_IDLE);
	assign len  = len_q;

endmodule

@@ hdl/glob_wildcard_matcher_core.sv @@
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_core: streaming glob matcher on a row of cells
// Each text byte moves the set of reachable pattern positions one step
// along the cell row; wildcard closure runs as one carry chain.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one word per text byte:
// text_byte, has_byte and last. A word with last set produces one word on
// the output channel (out_valid, out_stall) holding matched, registered in
// the output stage; words without last produce nothing.
// One input word is taken every cycle while in_stall is low. A two-entry
// output stage lets the input run on while a result waits; in_stall rises
// once both entries are full, and stays high until the receiver takes a word.
// The pattern is written through cfg_wr_en, cfg_index and cfg_data while the
// block is idle. After reset and after every register write the tokenizer
// sweeps the pattern one position per cycle up to its end, then loads the
// start set, with in_stall high throughout. After the sweep, and after every
// word with last, matching starts from the beginning.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        matched,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import gwm_pkg::*;

	tok_wr_t            tok;
	logic               busy;
	logic               load_start;
	logic [IDX_W-1:0]   len;
	logic [POS_W-1:0]   act_vec;
	logic [POS_W-1:0]   n_adv;
	logic [POS_W-1:0]   n_vec;
	logic [POS_W-1:0]   p_vec;
	logic [POS_W-1:0]   gen;
	logic [POS_W-1:0]   sum;
	logic [POS_W-1:0]   closed;
	logic [POS_W-1:0]   res;
	logic [POS_W-1:0]   act_d;
	logic [POS_W-1:0]   start_q;
	logic [PAT_MAX-1:0] step_out;
	logic               act_end_q;
	logic               act_load;
	logic               accept;
	logic               push;
	logic               take;
	logic               hit;
	logic               out_valid_q;
	logic               matched_q;
	logic               skid_valid_q;
	logic               skid_matched_q;

	gwm_tokenizer u_tok (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tok        (tok),
		.busy       (busy),
		.load_start (load_start),
		.len        (len)
	);

	assign accept   = in_valid && !in_stall;
	assign act_load = load_start || (accept && (last || has_byte));
	assign act_d    = (accept && last) ? start_q : closed;

	for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
		gwm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok       (tok),
			.sel       (tok.idx == CELL_W'(i)),
			.text_byte (text_byte),
			.step_in   ((i == 0) ? 1'b0 : step_out[(i == 0) ? 0 : i - 1]),
			.act_load  (act_load),
			.act_d     (act_d[i]),
			.act       (act_vec[i]),
			.nxt       (n_adv[i]),
			.step_out  (step_out[i]),
			.prop      (p_vec[i])
		);
	end

	// The end position never holds a token; it collects steps and closure carries.
	assign n_adv[PAT_MAX]   = step_out[PAT_MAX-1];
	assign p_vec[PAT_MAX]   = 1'b0;
	assign act_vec[PAT_MAX] = act_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_end_q <= 1'b0;
		end else if (act_load) begin
			act_end_q <= act_d[PAT_MAX];
		end
	end

	// Closure: a set position spreads right through every run of positions
	// that pass the closure on. Adding the pass mask to the set positions in
	// it makes the carries do exactly that spreading.
	assign n_vec  = load_start ? POS_W'(1) : n_adv;
	assign gen    = n_vec & p_vec;
	assign sum    = gen + p_vec;
	assign closed = n_vec | (sum ^ gen ^ p_vec);

	always_ff @(posedge clk) begin
		if (load_start) begin
			start_q <= closed;
		end
	end

	assign res  = has_byte ? closed : act_vec;
	assign hit  = res[len];
	assign push = accept && last;
	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				matched_q <= skid_matched_q;
			end
		end else if (!out_valid_q || take) begin
			if (push) begin
				matched_q <= hit;
			end
		end else if (push) begin
			skid_matched_q <= hit;
		end
	end

	assign in_stall  = busy || skid_valid_q;
	assign out_valid = out_valid_q;
	assign matched   = matched_q;

endmodule
